>>> hdl/latency_tier_governor_assert.svh
// Assertion macros used by the verification checker of the latency tier governor.
// Depends on nothing; the includer supplies the clock and the active-low reset.
`ifndef LATENCY_TIER_GOVERNOR_ASSERT_SVH
`define LATENCY_TIER_GOVERNOR_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define LTG_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("latency tier governor: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define LTG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("latency tier governor: next-cycle check failed");

`endif

>>> hdl/ltg_pkg.sv
// Shared types and constants of the latency tier governor.
// Depends on nothing; used by the interfaces, the top level and the checker.
package ltg_pkg;

    // Widths of the request, result and register fields.
    localparam int FuncW    = 2;
    localparam int LatW     = 16;
    localparam int AvgW     = 18;
    localparam int CountW   = 32;
    localparam int TierW    = 2;
    localparam int CalmW    = 8;
    localparam int PinW     = 3;
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 16;
    localparam int NumTiers = 4;

    // Reset values of the registers and the calm-run saturation limit.
    localparam logic [LatW-1:0]  MidThresholdRst   = 16'd2048;
    localparam logic [LatW-1:0]  HighThresholdRst  = 16'd3072;
    localparam logic [LatW-1:0]  EmergThresholdRst = 16'd3968;
    localparam logic [CalmW-1:0] StepDownRst       = 8'd4;
    localparam logic [PinW-1:0]  PinnedTierRst     = 3'b111;
    localparam logic [CalmW-1:0] CalmMax           = 8'd255;

    // Request function codes.
    typedef enum logic [FuncW-1:0] {
        FUNC_SAMPLE = 2'd0,
        FUNC_CLEAR  = 2'd1,
        FUNC_ACK    = 2'd2
    } func_t;

    // Tier codes.
    typedef enum logic [TierW-1:0] {
        TIER_FULL     = 2'd0,
        TIER_FAST     = 2'd1,
        TIER_OFFLOAD  = 2'd2,
        TIER_FAILOVER = 2'd3
    } tier_t;

    // Register indexes of the configuration port.
    typedef enum logic [CfgIdxW-1:0] {
        CFG_MID_THRESHOLD   = 3'd0,
        CFG_HIGH_THRESHOLD  = 3'd1,
        CFG_EMERG_THRESHOLD = 3'd2,
        CFG_STEP_DOWN       = 3'd3,
        CFG_GOVERNOR_ON     = 3'd4,
        CFG_OFFLOAD_ALLOWED = 3'd5,
        CFG_PINNED_TIER     = 3'd6
    } cfg_index_t;

    // One result as it sits in the output stage.
    typedef struct packed {
        logic [TierW-1:0]  tier;
        logic [AvgW-1:0]   average;
        logic [LatW-1:0]   last_sample;
        logic [CountW-1:0] frame_total;
        logic [CountW-1:0] full_count;
        logic [CountW-1:0] fast_count;
        logic [CountW-1:0] offload_count;
        logic [CountW-1:0] failover_count;
    } result_t;

endpackage

>>> hdl/ltg_channels.sv
// Valid/ready channel interfaces of the latency tier governor: requests, results, configuration.
// Depends on ltg_pkg for the field widths.

// Request channel: one event per request.
interface ltg_cmd_if;
    logic                      valid;
    logic                      ready;
    logic [ltg_pkg::FuncW-1:0] func;
    logic [ltg_pkg::LatW-1:0]  latency;

    modport source (output valid, output func, output latency, input ready);
    modport sink   (input valid, input func, input latency, output ready);
endinterface

// Result channel: one report per request.
interface ltg_res_if;
    logic                       valid;
    logic                       ready;
    logic [ltg_pkg::TierW-1:0]  tier;
    logic [ltg_pkg::AvgW-1:0]   average;
    logic [ltg_pkg::LatW-1:0]   last_sample;
    logic [ltg_pkg::CountW-1:0] frame_total;
    logic [ltg_pkg::CountW-1:0] full_count;
    logic [ltg_pkg::CountW-1:0] fast_count;
    logic [ltg_pkg::CountW-1:0] offload_count;
    logic [ltg_pkg::CountW-1:0] failover_count;

    modport source (output valid, output tier, output average, output last_sample,
                    output frame_total, output full_count, output fast_count,
                    output offload_count, output failover_count, input ready);
    modport sink   (input valid, input tier, input average, input last_sample,
                    input frame_total, input full_count, input fast_count,
                    input offload_count, input failover_count, output ready);
endinterface

// Configuration write channel.
interface ltg_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [ltg_pkg::CfgIdxW-1:0]  index;
    logic [ltg_pkg::CfgDataW-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hdl/latency_tier_governor.sv
// Latency tier governor top level: averaging, tier decision, frame counters and output stage.
// Depends on ltg_pkg and the channel interfaces in ltg_channels.sv.
//
// Usage:
// - cmd carries one event per request: func 0 is a frame latency sample, func 1 clears
//   the averaging and the tier, func 2 acknowledges a failover; func 3 changes nothing.
// - res returns exactly one report per request, in request order: effective tier,
//   moving average, last sample, total frames and the four per-tier frame counters.
// - cfg writes one register per request and is always ready; write it only while idle.
// - A report is registered in the output stage, or in the skid register while res
//   stalls. A request is taken in every cycle while the skid register is empty; the
//   whole update is one pass of shift-add and compare logic between the state registers.
// - When res stalls, one more request is taken into a skid register, and cmd.ready
//   then drops until the receiver takes the waiting report.
// - Reset loads the register defaults, clears the average, tier and counters, and
//   empties the output stage.
module latency_tier_governor (
    input  logic      clk,
    input  logic      rst_n,
    ltg_cmd_if.sink   cmd,
    ltg_res_if.source res,
    ltg_cfg_if.sink   cfg
);

    // Configuration registers.
    logic [ltg_pkg::LatW-1:0]  mid_threshold_reg;
    logic [ltg_pkg::LatW-1:0]  high_threshold_reg;
    logic [ltg_pkg::LatW-1:0]  emerg_threshold_reg;
    logic [ltg_pkg::CalmW-1:0] step_down_reg;
    logic                      governor_on_reg;
    logic                      offload_allowed_reg;
    logic [ltg_pkg::PinW-1:0]  pinned_tier_reg;

    // Governor state.
    logic [ltg_pkg::TierW-1:0]  level_reg, level_next;
    logic [ltg_pkg::AvgW-1:0]   smoothed_reg, smoothed_next;
    logic [ltg_pkg::LatW-1:0]   prev_sample_reg, prev_sample_next;
    logic [ltg_pkg::CalmW-1:0]  calm_run_reg, calm_run_next;
    logic [ltg_pkg::CountW-1:0] frames_reg, frames_next;
    logic [ltg_pkg::CountW-1:0] tier_count_reg [ltg_pkg::NumTiers];
    logic [ltg_pkg::CountW-1:0] tier_count_next [ltg_pkg::NumTiers];

    // Output stage and skid register.
    logic             out_valid_reg, out_valid_next;
    logic             skid_valid_reg, skid_valid_next;
    ltg_pkg::result_t out_data_reg, out_data_next;
    ltg_pkg::result_t skid_data_reg, skid_data_next;

    // Datapath signals.
    logic                      cmd_fire;
    logic                      res_free;
    logic                      pinned;
    logic [ltg_pkg::TierW-1:0] capped_tier;
    logic [ltg_pkg::AvgW+2:0]  blend_sum;
    logic [ltg_pkg::AvgW-1:0]  avg_new;
    logic                      above_high;
    logic                      above_mid;
    logic                      emergency;
    logic [ltg_pkg::CalmW-1:0] calm_inc;
    logic                      calm_done;
    logic                      count_frame;
    logic [ltg_pkg::TierW-1:0] eff_tier;
    ltg_pkg::result_t          result;

    // Handshakes: the skid register decides whether a request can be taken.
    assign cmd.ready = !skid_valid_reg;
    assign cfg.ready = 1'b1;
    assign cmd_fire  = cmd.valid && !skid_valid_reg;
    assign res_free  = !out_valid_reg || res.ready;

    // Configuration writes; indexes beyond the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_threshold_reg   <= ltg_pkg::MidThresholdRst;
            high_threshold_reg  <= ltg_pkg::HighThresholdRst;
            emerg_threshold_reg <= ltg_pkg::EmergThresholdRst;
            step_down_reg       <= ltg_pkg::StepDownRst;
            governor_on_reg     <= 1'b0;
            offload_allowed_reg <= 1'b0;
            pinned_tier_reg     <= ltg_pkg::PinnedTierRst;
        end
        else if (cfg.valid)
        begin
            case (ltg_pkg::cfg_index_t'(cfg.index))
                ltg_pkg::CFG_MID_THRESHOLD:   mid_threshold_reg   <= cfg.data;
                ltg_pkg::CFG_HIGH_THRESHOLD:  high_threshold_reg  <= cfg.data;
                ltg_pkg::CFG_EMERG_THRESHOLD: emerg_threshold_reg <= cfg.data;
                ltg_pkg::CFG_STEP_DOWN:       step_down_reg       <= cfg.data[ltg_pkg::CalmW-1:0];
                ltg_pkg::CFG_GOVERNOR_ON:     governor_on_reg     <= cfg.data[0];
                ltg_pkg::CFG_OFFLOAD_ALLOWED: offload_allowed_reg <= cfg.data[0];
                ltg_pkg::CFG_PINNED_TIER:     pinned_tier_reg     <= cfg.data[ltg_pkg::PinW-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // A non-negative pinned tier forces the report and freezes sampling.
    assign pinned      = !pinned_tier_reg[ltg_pkg::PinW-1];
    assign capped_tier = offload_allowed_reg ? ltg_pkg::TIER_OFFLOAD : ltg_pkg::TIER_FAST;

    // Quarter-weight average in 1/1024 ms; the first sample seeds it.
    assign blend_sum = {3'b000, smoothed_reg} + {2'b00, smoothed_reg, 1'b0}
                     + {3'b000, cmd.latency, 2'b00};
    assign avg_new   = (smoothed_reg == '0) ? {cmd.latency, 2'b00}
                                            : blend_sum[ltg_pkg::AvgW+1:2];

    // Threshold compares: averages against four times the threshold, the raw sample as is.
    assign above_high = avg_new >= {high_threshold_reg, 2'b00};
    assign above_mid  = avg_new >= {mid_threshold_reg, 2'b00};
    assign emergency  = cmd.latency >= emerg_threshold_reg;

    // Saturating calm-run count and the step-down test.
    assign calm_inc  = (calm_run_reg == ltg_pkg::CalmMax) ? calm_run_reg
                                                          : calm_run_reg + 8'd1;
    assign calm_done = calm_inc >= step_down_reg;

    // Next state of the governor for the request at the input.
    always_comb
    begin
        level_next       = level_reg;
        smoothed_next    = smoothed_reg;
        prev_sample_next = prev_sample_reg;
        calm_run_next    = calm_run_reg;
        frames_next      = frames_reg;
        count_frame      = 1'b0;
        case (ltg_pkg::func_t'(cmd.func))
            ltg_pkg::FUNC_SAMPLE:
            begin
                if (!pinned && governor_on_reg)
                begin
                    prev_sample_next = cmd.latency;
                    frames_next      = frames_reg + 32'd1;
                    smoothed_next    = avg_new;
                    count_frame      = 1'b1;
                    if (emergency)
                    begin
                        level_next    = ltg_pkg::TIER_FAILOVER;
                        calm_run_next = '0;
                    end
                    else if (level_reg == ltg_pkg::TIER_FAILOVER)
                    begin
                        level_next    = capped_tier;
                        calm_run_next = '0;
                    end
                    else if (above_high)
                    begin
                        if (level_reg < capped_tier)
                        begin
                            level_next = capped_tier;
                        end
                        calm_run_next = '0;
                    end
                    else if (level_reg == ltg_pkg::TIER_OFFLOAD)
                    begin
                        calm_run_next = calm_done ? '0 : calm_inc;
                        if (calm_done)
                        begin
                            level_next = above_mid ? ltg_pkg::TIER_FAST : ltg_pkg::TIER_FULL;
                        end
                    end
                    else if (above_mid)
                    begin
                        if (level_reg == ltg_pkg::TIER_FULL)
                        begin
                            level_next = ltg_pkg::TIER_FAST;
                        end
                        calm_run_next = '0;
                    end
                    else if (level_reg == ltg_pkg::TIER_FAST)
                    begin
                        calm_run_next = calm_done ? '0 : calm_inc;
                        if (calm_done)
                        begin
                            level_next = ltg_pkg::TIER_FULL;
                        end
                    end
                    else
                    begin
                        calm_run_next = '0;
                    end
                end
            end
            ltg_pkg::FUNC_CLEAR:
            begin
                smoothed_next    = '0;
                prev_sample_next = '0;
                calm_run_next    = '0;
                level_next       = pinned ? pinned_tier_reg[ltg_pkg::TierW-1:0]
                                          : ltg_pkg::TIER_FULL;
            end
            ltg_pkg::FUNC_ACK:
            begin
                if (level_reg == ltg_pkg::TIER_FAILOVER)
                begin
                    level_next    = capped_tier;
                    calm_run_next = '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Per-tier frame counters count the tier a governed frame ends in.
    always_comb
    begin
        for (int i = 0; i < ltg_pkg::NumTiers; i++)
        begin
            tier_count_next[i] = tier_count_reg[i];
            if (count_frame && (level_next == ltg_pkg::TierW'(i)))
            begin
                tier_count_next[i] = tier_count_reg[i] + 32'd1;
            end
        end
    end

    // Governor state registers, updated on each accepted request.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg       <= ltg_pkg::TIER_FULL;
            smoothed_reg    <= '0;
            prev_sample_reg <= '0;
            calm_run_reg    <= '0;
            frames_reg      <= '0;
            for (int i = 0; i < ltg_pkg::NumTiers; i++)
            begin
                tier_count_reg[i] <= '0;
            end
        end
        else if (cmd_fire)
        begin
            level_reg       <= level_next;
            smoothed_reg    <= smoothed_next;
            prev_sample_reg <= prev_sample_next;
            calm_run_reg    <= calm_run_next;
            frames_reg      <= frames_next;
            for (int i = 0; i < ltg_pkg::NumTiers; i++)
            begin
                tier_count_reg[i] <= tier_count_next[i];
            end
        end
    end

    // Report: pinned tier first, then tier zero when not governing, else the level.
    assign eff_tier = pinned           ? pinned_tier_reg[ltg_pkg::TierW-1:0] :
                      !governor_on_reg ? ltg_pkg::TIER_FULL : level_next;

    always_comb
    begin
        result.tier           = eff_tier;
        result.average        = smoothed_next;
        result.last_sample    = prev_sample_next;
        result.frame_total    = frames_next;
        result.full_count     = tier_count_next[0];
        result.fast_count     = tier_count_next[1];
        result.offload_count  = tier_count_next[2];
        result.failover_count = tier_count_next[3];
    end

    // Output stage: the skid register drains first, so order is kept.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (res_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = cmd_fire;
                out_data_next  = result;
            end
        end
        else if (cmd_fire)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Result payload registers need no reset.
    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign res.valid          = out_valid_reg;
    assign res.tier           = out_data_reg.tier;
    assign res.average        = out_data_reg.average;
    assign res.last_sample    = out_data_reg.last_sample;
    assign res.frame_total    = out_data_reg.frame_total;
    assign res.full_count     = out_data_reg.full_count;
    assign res.fast_count     = out_data_reg.fast_count;
    assign res.offload_count  = out_data_reg.offload_count;
    assign res.failover_count = out_data_reg.failover_count;

endmodule

>>> hdl/ltg_checker.sv
// Port-level checker of the latency tier governor, bound to the top level.
// Depends on ltg_pkg and the macros in latency_tier_governor_assert.svh.
`include "latency_tier_governor_assert.svh"

module ltg_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       cmd_valid,
    input logic                       cmd_ready,
    input logic                       res_valid,
    input logic                       res_ready,
    input logic [ltg_pkg::TierW-1:0]  res_tier,
    input logic [ltg_pkg::AvgW-1:0]   res_average,
    input logic [ltg_pkg::CountW-1:0] res_frame_total
);

    // A stalled report holds its contents.
    `LTG_ASSERT_NEXT(a_res_hold, clk, rst_n, res_valid && !res_ready, res_valid && $stable(res_tier) && $stable(res_average) && $stable(res_frame_total))

    // A request taken while the output is free shows up as a report next cycle.
    `LTG_ASSERT_NEXT(a_res_follows, clk, rst_n, cmd_valid && cmd_ready && (!res_valid || res_ready), res_valid)

    // A request taken behind a stalled report fills the skid register and blocks the next.
    `LTG_ASSERT_NEXT(a_skid_full, clk, rst_n, cmd_valid && cmd_ready && res_valid && !res_ready, !cmd_ready)

    // The input only blocks while a report is waiting.
    `LTG_ASSERT_SAME(a_block_cause, clk, rst_n, !cmd_ready, res_valid)

endmodule

bind latency_tier_governor ltg_checker u_ltg_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_valid       (cmd.valid),
    .cmd_ready       (cmd.ready),
    .res_valid       (res.valid),
    .res_ready       (res.ready),
    .res_tier        (res.tier),
    .res_average     (res.average),
    .res_frame_total (res.frame_total)
);
